// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file gspl_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

// ===== sv/gspl_pkg.sv =====
// types, constants and tables for the gas sensor ppm linearizer
// used by gspl_log2, gas_sensor_ppm_linearizer and gspl_checker
package gspl_pkg;

   localparam int SAMPLES_PER_READING_DEF = 10;

   localparam logic [23:0] PPM_MAX          = 24'hFFFFFF;
   localparam logic [15:0] CAL_WINDOW_RST   = 16'd3000;
   localparam logic [15:0] LOAD_RES_RST     = 16'd1306;
   localparam logic [23:0] REF_RES_RST      = 24'd13148;
   localparam logic [13:0] INV_CAL_RATIO    = 14'd13667;
   localparam int          LOG2_SCALE_Q16   = 695954;
   localparam int          EXPONENT_Q16     = 95551;

   // resistance numerator / quotient width
   localparam int NUM_W = 52;
   localparam int ACC_W = 66;
   localparam int LOG_W = 22;

   typedef enum logic [0:0] {
      CSR_CAL_WINDOW = 1'b0,
      CSR_LOAD_RES   = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_AVG, ST_CV, ST_MUL, ST_DIV, ST_CAL, ST_CALSAT,
      ST_CHECK, ST_LOGA, ST_LOGB, ST_ROUND, ST_EXP, ST_FINAL, ST_DONE
   } gspl_state_type;

   typedef enum logic [1:0] {
      LOG_IDLE, LOG_NORM, LOG_SQ
   } log_state_type;

   typedef struct packed {
      logic start;
   } log_ctl_type;

   typedef struct packed {
      logic             done;
      logic [LOG_W-1:0] result;
   } log_stat_type;

   // 2^(2^-(k+1)) in Q30
   function automatic logic [30:0] exp2_step(input logic [3:0] k);
      logic [30:0] v;
      case (k)
         4'd0:    v = 31'd1518500250;
         4'd1:    v = 31'd1276901417;
         4'd2:    v = 31'd1170923762;
         4'd3:    v = 31'd1121280436;
         4'd4:    v = 31'd1097253712;
         4'd5:    v = 31'd1085434106;
         4'd6:    v = 31'd1079572146;
         4'd7:    v = 31'd1076653033;
         4'd8:    v = 31'd1075196443;
         4'd9:    v = 31'd1074468889;
         4'd10:   v = 31'd1074105300;
         4'd11:   v = 31'd1073923544;
         4'd12:   v = 31'd1073832681;
         4'd13:   v = 31'd1073787251;
         4'd14:   v = 31'd1073764537;
         default: v = 31'd1073753181;
      endcase
      return v;
   endfunction

endpackage

// ===== sv/gspl_log2.sv =====
// log2 unit in Q16: bit-serial normalize, then sixteen squaring steps
// depends on gspl_pkg
module gspl_log2 import gspl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  log_ctl_type      ctl,
   input  logic [NUM_W-1:0] operand,
   output log_stat_type     stat
);

   log_state_type    state_ff, state_in;
   logic [NUM_W-1:0] xn_ff, xn_in;
   logic [5:0]       p_ff, p_in;
   logic [30:0]      m_ff, m_in;
   logic [15:0]      frac_ff, frac_in;
   logic [3:0]       step_ff, step_in;
   logic             done_ff, done_in;

   logic        norm_more;
   logic [61:0] sq;
   logic [31:0] sq_sh;
   logic        load_op, do_shift, do_square, last_sq;

   assign norm_more = !xn_ff[NUM_W-1] && (p_ff != 6'd0);
   assign sq        = 62'(m_ff) * 62'(m_ff);
   assign sq_sh     = sq[61:30];
   assign last_sq   = (step_ff == 4'd15);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         LOG_IDLE: if (ctl.start) state_in = LOG_NORM;
         LOG_NORM: if (!norm_more) state_in = LOG_SQ;
         LOG_SQ:   if (last_sq) state_in = LOG_IDLE;
         default:  state_in = LOG_IDLE;
      endcase
   end

   // step controls
   always_comb begin
      load_op   = 1'b0;
      do_shift  = 1'b0;
      do_square = 1'b0;
      case (state_ff)
         LOG_IDLE: load_op   = ctl.start;
         LOG_NORM: do_shift  = norm_more;
         LOG_SQ:   do_square = 1'b1;
         default:  load_op   = 1'b0;
      endcase
   end

   // datapath
   always_comb begin
      xn_in   = xn_ff;
      p_in    = p_ff;
      m_in    = m_ff;
      frac_in = frac_ff;
      step_in = step_ff;
      done_in = (state_ff == LOG_SQ) && last_sq;
      if (load_op) begin
         xn_in = operand;
         p_in  = 6'(NUM_W - 1);
      end
      if (state_ff == LOG_NORM) begin
         if (do_shift) begin
            xn_in = {xn_ff[NUM_W-2:0], 1'b0};
            p_in  = p_ff - 6'd1;
         end else begin
            m_in    = xn_ff[NUM_W-1:NUM_W-31];
            frac_in = 16'd0;
            step_in = 4'd0;
         end
      end
      if (do_square) begin
         if (sq_sh[31]) begin
            m_in    = sq_sh[31:1];
            frac_in = frac_ff | (16'd1 << (4'd15 - step_ff));
         end else begin
            m_in = sq_sh[30:0];
         end
         step_in = step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LOG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      xn_ff   <= xn_in;
      p_ff    <= p_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      step_ff <= step_in;
   end

   assign stat.done   = done_ff;
   assign stat.result = {p_ff, frac_ff};

endmodule

// ===== sv/gas_sensor_ppm_linearizer.sv =====
// Gas sensor ppm linearizer: averages a reading of samples, converts to ppm.
// A sample that does not close a reading is taken with no result; a closing sample's
// result is ready soonest at zero voltage, later at zero resistance or zero reference,
// and latest otherwise; the 52-step bit-serial divider and the one-bit-per-cycle normalize
// of the log2 unit (run twice) take most of that time.
// Throughput: samples back to back until a reading closes; the next is taken in the cycle
// after the result is handed off. Reset (synchronous): clears sum, count, loads R0.
module gas_sensor_ppm_linearizer import gspl_pkg::*; #(
   parameter int SAMPLES_PER_READING = SAMPLES_PER_READING_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [11:0]   req_adc_sample,
   input  logic [31:0]   req_elapsed_ms,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [23:0]   rsp_ppm_q4,
   output logic          rsp_calibrated_now,
   output logic          rsp_zero_voltage_error,
   input  logic          csr_write_enable,
   input  csr_index_type csr_index,
   input  logic [15:0]   csr_write_data
);

   localparam int CNT_W = $clog2(SAMPLES_PER_READING + 1);

   gspl_state_type   state_ff, state_in;
   logic [15:0]      sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      window_ff, window_in;
   logic [15:0]      load_ff, load_in;
   logic [23:0]      r0_ff, r0_in;
   logic             cal_req_ff, cal_req_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [13:0]      rem_ff, rem_in;
   logic [12:0]      cv_ff, cv_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [LOG_W-1:0] la_ff, la_in;
   logic signed [40:0] prod_ff, prod_in;
   logic [15:0]      frac_ff, frac_in;
   logic [4:0]       int_ff, int_in;
   logic [30:0]      em_ff, em_in;
   logic [23:0]      res_ppm_ff, res_ppm_in;
   logic             res_cal_ff, res_cal_in;
   logic             res_err_ff, res_err_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [23:0]      rsp_ppm_ff, rsp_ppm_in;
   logic             rsp_cal_ff, rsp_cal_in;
   logic             rsp_err_ff, rsp_err_in;

   log_ctl_type      log_ctl;
   log_stat_type     log_stat;
   logic [NUM_W-1:0] log_operand;

   logic             accept, last_sample, out_free, rsp_load;
   logic [CNT_W-1:0] count_next;
   logic [15:0]      sum_next;
   logic [13:0]      divisor, div_t, div_rem;
   logic             div_ge;
   logic [24:0]      cv_prod;
   logic [12:0]      cv_w;
   logic [31:0]      diff;
   logic [ACC_W-1:0] acc_shift, acc_mul, acc_cal;
   logic [ACC_W-1:0] r0_sum;
   logic [49:0]      r0_sh;
   logic [23:0]      r0_new;
   logic signed [22:0] d_s;
   logic             p_neg;
   logic [40:0]      pa, qa_sum;
   logic [24:0]      qa;
   logic signed [25:0] q_s, e_s, eu_s;
   logic             e_high, e_low;
   logic [62:0]      eprod;
   logic [30:0]      em_next;
   logic [4:0]       sh;
   logic [32:0]      fin_rnd, fin_r;
   logic [23:0]      fin_ppm;

   assign accept      = req_valid && !req_stall;
   assign count_next  = count_ff + CNT_W'(1);
   assign sum_next    = sum_ff + {4'd0, req_adc_sample};
   assign last_sample = (count_next == CNT_W'(SAMPLES_PER_READING));
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // shared restoring divider step
   assign divisor = (state_ff == ST_AVG) ? 14'(SAMPLES_PER_READING) : {1'b0, cv_ff};
   assign div_t   = {rem_ff[12:0], num_ff[NUM_W-1]};
   assign div_ge  = (div_t >= divisor);
   assign div_rem = div_ge ? (div_t - divisor) : div_t;

   // centivolts from the average
   assign cv_prod = 25'(num_ff[15:0]) * 25'd330 + 25'd2048;
   assign cv_w    = cv_prod[24:12];
   assign diff    = 32'd330 - {19'd0, cv_ff};

   // shift-add multiplier steps
   assign acc_shift = {acc_ff[ACC_W-2:0], 1'b0};
   assign acc_mul   = acc_shift + (load_ff[4'd15 - cnt_ff[3:0]] ? ACC_W'(diff) : '0);
   assign acc_cal   = acc_shift + (INV_CAL_RATIO[4'd13 - cnt_ff[3:0]] ? ACC_W'(num_ff) : '0);

   // new reference resistance, rounded and saturated
   assign r0_sum = acc_ff + ACC_W'(32768);
   assign r0_sh  = r0_sum[65:16];
   assign r0_new = (|r0_sh[49:24]) ? PPM_MAX : r0_sh[23:0];

   // exponent scaling and rounding half away from zero
   assign d_s    = $signed({1'b0, la_ff}) - $signed({1'b0, log_stat.result});
   assign p_neg  = prod_ff[40];
   assign pa     = p_neg ? 41'(-prod_ff) : 41'(prod_ff);
   assign qa_sum = pa + 41'd32768;
   assign qa     = qa_sum[40:16];
   assign q_s    = p_neg ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
   assign e_s    = 26'(LOG2_SCALE_Q16) - q_s;
   assign e_high = (e_s >= 26'sd1572864);
   assign e_low  = (e_s < -26'sd65536);
   assign eu_s   = e_s + 26'sd65536;

   // exp2 product step
   assign eprod   = 63'(em_ff) * 63'(exp2_step(cnt_ff[3:0])) + 63'(1 << 29);
   assign em_next = eprod[60:30];

   // final shift to Q4
   assign sh      = 5'd31 - int_ff;
   assign fin_rnd = 33'(em_ff) + (33'd1 << (sh - 5'd1));
   assign fin_r   = fin_rnd >> sh;
   assign fin_ppm = (|fin_r[32:24]) ? PPM_MAX : fin_r[23:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept && last_sample) state_in = ST_AVG;
         ST_AVG:    if (cnt_ff == 6'd15) state_in = ST_CV;
         ST_CV:     state_in = (cv_w == 13'd0) ? ST_DONE : ST_MUL;
         ST_MUL:    if (cnt_ff == 6'd15) state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == 6'(NUM_W - 1)) state_in = cal_req_ff ? ST_CAL : ST_CHECK;
         end
         ST_CAL:    if (cnt_ff == 6'd13) state_in = ST_CALSAT;
         ST_CALSAT: state_in = ST_CHECK;
         ST_CHECK: begin
            if (num_ff == '0 || r0_ff == 24'd0) state_in = ST_DONE;
            else state_in = ST_LOGA;
         end
         ST_LOGA:   if (log_stat.done) state_in = ST_LOGB;
         ST_LOGB:   if (log_stat.done) state_in = ST_ROUND;
         ST_ROUND:  state_in = (e_high || e_low) ? ST_DONE : ST_EXP;
         ST_EXP:    if (cnt_ff == 6'd15) state_in = ST_FINAL;
         ST_FINAL:  state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall     = 1'b1;
      log_ctl.start = 1'b0;
      log_operand   = num_ff;
      rsp_load      = 1'b0;
      case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_CHECK: log_ctl.start = (num_ff != '0) && (r0_ff != 24'd0);
         ST_LOGA: begin
            log_ctl.start = log_stat.done;
            log_operand   = NUM_W'(r0_ff);
         end
         ST_DONE:  rsp_load = out_free;
         default:  req_stall = 1'b1;
      endcase
   end

   // datapath next values
   always_comb begin
      sum_in     = sum_ff;
      count_in   = count_ff;
      window_in  = window_ff;
      load_in    = load_ff;
      r0_in      = r0_ff;
      cal_req_in = cal_req_ff;
      cnt_in     = cnt_ff + 6'd1;
      num_in     = num_ff;
      rem_in     = rem_ff;
      cv_in      = cv_ff;
      acc_in     = acc_ff;
      la_in      = la_ff;
      prod_in    = prod_ff;
      frac_in    = frac_ff;
      int_in     = int_ff;
      em_in      = em_ff;
      res_ppm_in = res_ppm_ff;
      res_cal_in = res_cal_ff;
      res_err_in = res_err_ff;

      // configuration writes
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CAL_WINDOW: window_in = csr_write_data;
            CSR_LOAD_RES:   load_in   = csr_write_data;
            default:        window_in = window_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            cnt_in = 6'd0;
            if (accept) begin
               if (last_sample) begin
                  sum_in     = 16'd0;
                  count_in   = '0;
                  num_in     = {sum_next, 36'd0};
                  rem_in     = 14'd0;
                  cal_req_in = (req_elapsed_ms < {16'd0, window_ff});
                  res_cal_in = 1'b0;
                  res_err_in = 1'b0;
               end else begin
                  sum_in   = sum_next;
                  count_in = count_next;
               end
            end
         end
         ST_AVG: begin
            rem_in = div_rem;
            num_in = {num_ff[NUM_W-2:0], div_ge};
         end
         ST_CV: begin
            cv_in  = cv_w;
            cnt_in = 6'd0;
            acc_in = '0;
            if (cv_w == 13'd0) begin
               res_ppm_in = PPM_MAX;
               res_err_in = 1'b1;
            end
         end
         ST_MUL: begin
            acc_in = acc_mul;
            if (cnt_ff == 6'd15) begin
               num_in = {acc_mul[47:0], 4'd0};
               rem_in = 14'd0;
               cnt_in = 6'd0;
            end
         end
         ST_DIV: begin
            rem_in = div_rem;
            num_in = {num_ff[NUM_W-2:0], div_ge};
            if (cnt_ff == 6'(NUM_W - 1)) begin
               cnt_in = 6'd0;
               acc_in = '0;
            end
         end
         ST_CAL:    acc_in = acc_cal;
         ST_CALSAT: begin
            r0_in      = r0_new;
            res_cal_in = 1'b1;
         end
         ST_CHECK: begin
            if (num_ff == '0) res_ppm_in = PPM_MAX;
            else if (r0_ff == 24'd0) res_ppm_in = 24'd0;
         end
         ST_LOGA:   if (log_stat.done) la_in = log_stat.result;
         ST_LOGB:   prod_in = 41'(d_s) * 41'sd95551;
         ST_ROUND: begin
            cnt_in  = 6'd0;
            frac_in = eu_s[15:0];
            int_in  = eu_s[20:16];
            em_in   = 31'd1 << 30;
            if (e_high) res_ppm_in = PPM_MAX;
            else if (e_low) res_ppm_in = 24'd0;
         end
         ST_EXP:    if (frac_ff[4'd15 - cnt_ff[3:0]]) em_in = em_next;
         ST_FINAL:  res_ppm_in = fin_ppm;
         default:   cnt_in = cnt_ff;
      endcase
   end

   // result register toward the consumer
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ppm_in   = rsp_ppm_ff;
      rsp_cal_in   = rsp_cal_ff;
      rsp_err_in   = rsp_err_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_ppm_in   = res_ppm_ff;
         rsp_cal_in   = res_cal_ff;
         rsp_err_in   = res_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= 16'd0;
         count_ff     <= '0;
         window_ff    <= CAL_WINDOW_RST;
         load_ff      <= LOAD_RES_RST;
         r0_ff        <= REF_RES_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         window_ff    <= window_in;
         load_ff      <= load_in;
         r0_ff        <= r0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cal_req_ff <= cal_req_in;
      cnt_ff     <= cnt_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      cv_ff      <= cv_in;
      acc_ff     <= acc_in;
      la_ff      <= la_in;
      prod_ff    <= prod_in;
      frac_ff    <= frac_in;
      int_ff     <= int_in;
      em_ff      <= em_in;
      res_ppm_ff <= res_ppm_in;
      res_cal_ff <= res_cal_in;
      res_err_ff <= res_err_in;
      rsp_ppm_ff <= rsp_ppm_in;
      rsp_cal_ff <= rsp_cal_in;
      rsp_err_ff <= rsp_err_in;
   end

   // log2 unit, shared by both resistances
   gspl_log2 u_log2 (
      .clock   (clock),
      .reset   (reset),
      .ctl     (log_ctl),
      .operand (log_operand),
      .stat    (log_stat)
   );

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_ppm_q4             = rsp_ppm_ff;
   assign rsp_calibrated_now     = rsp_cal_ff;
   assign rsp_zero_voltage_error = rsp_err_ff;

endmodule

// ===== sv/gspl_checker.sv =====
// port-level checks for gas_sensor_ppm_linearizer, bound to the top level
// depends on gspl_pkg and assert_macros.svh
`include "assert_macros.svh"

module gspl_checker import gspl_pkg::*; (
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_stall,
   input logic [11:0]   req_adc_sample,
   input logic [31:0]   req_elapsed_ms,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input logic [23:0]   rsp_ppm_q4,
   input logic          rsp_calibrated_now,
   input logic          rsp_zero_voltage_error,
   input logic          csr_write_enable,
   input csr_index_type csr_index,
   input logic [15:0]   csr_write_data
);

   // a stalled transaction holds its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_ppm_q4) && $stable(rsp_calibrated_now) && $stable(rsp_zero_voltage_error))

   // zero voltage saturates and never recalibrates
   `ASSERT_IMPLY(a_err_sat, clock, reset, rsp_valid && rsp_zero_voltage_error, rsp_ppm_q4 == PPM_MAX && !rsp_calibrated_now)

   // a new result only appears after the block was busy computing
   `ASSERT_IMPLY(a_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

bind gas_sensor_ppm_linearizer gspl_checker u_gspl_checker (.*);
